// ===== rtl/core/lrp_pkg.sv =====
`timescale 1ns / 1ps

package lrp_pkg;

    localparam int TAU_W   = 16;
    localparam int TEMP_W  = 15;
    localparam int MEAN_W  = 14;
    localparam int ACC_W   = 48;
    localparam int DIFF_W  = 14;
    localparam int PRED_W  = 52;
    localparam int ORDER_W = 3;

    // shared multiplier: 17x16 lapse term, or up to 39x14 for the power steps
    localparam int MUL_A_W = 39;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = 33;

    localparam int REG_POWER_ORDER = 0;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_MAX   = 3'd4;

    localparam logic signed [DIFF_W-1:0] DIFF_LIMIT = 14'sd6400;
    localparam logic signed [ACC_W-1:0]  ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W:0]    ROUND_HALF = 49'sd16384;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;

endpackage

// ===== rtl/core/lrp_mult.sv =====
`timescale 1ns / 1ps

module lrp_mult
(
    input  logic            clk,
    input  lrp_pkg::mul_a_t a,
    input  lrp_pkg::mul_b_t b,
    output lrp_pkg::mul_p_t product
);

    lrp_pkg::mul_p_t product_reg;
    lrp_pkg::mul_p_t product_next;

    always_comb
    begin
        product_next = lrp_pkg::mul_p_t'(a) * lrp_pkg::mul_p_t'(b);
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

// ===== rtl/core/lrp_cfg.sv =====
`timescale 1ns / 1ps

module lrp_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [lrp_pkg::ORDER_W-1:0]      power_order
);

    logic [lrp_pkg::ORDER_W-1:0] order_reg;
    logic [lrp_pkg::ORDER_W-1:0] order_next;
    logic                        hit;

    // word index; byte offset bits do not select a register
    assign hit = ({1'b0, paddr[2]} == 2'(lrp_pkg::REG_POWER_ORDER)) && (paddr[1:0] == paddr[1:0]);

    always_comb
    begin
        order_next = order_reg;
        if (psel && penable && pwrite && hit)
        begin
            order_next = pwdata[lrp_pkg::ORDER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= lrp_pkg::ORDER_RESET;
        end
        else
        begin
            order_reg <= order_next;
        end
    end

    assign pready      = 1'b1;
    assign prdata      = hit ? {{(32-lrp_pkg::ORDER_W){1'b0}}, order_reg} : 32'd0;
    assign power_order = order_reg;

endmodule

// ===== rtl/core/lapse_rate_predictor_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Transfer when              Contents
// s_*      in   s_tvalid & s_tready        one profile level
// m_*      out  m_tvalid & m_tready        predictor result
// apb      in   psel & penable & pwrite    power_order at word address 0
//
// A first level item takes only an accept step. Other level items are accepted,
// multiplied and accumulated on the shared multiplier. The last level adds a
// rounding step, order - 1 power steps (ST_POW, ST_POWW) and an output load step.
// s_tready is low while an item is in work; a stalled result register holds
// the sequencer in its output step. Reset clears all state, order resets to 1.

module lapse_rate_predictor_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // transmittance, level_temperature, surface_temperature, channel_mean
    input  logic        s_tlast,
    input  logic        s_tuser,   // first_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // predictor_value
    output logic        m_tuser,   // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TAU_W  = lrp_pkg::TAU_W;
    localparam int TEMP_W = lrp_pkg::TEMP_W;
    localparam int MEAN_W = lrp_pkg::MEAN_W;
    localparam int ACC_W  = lrp_pkg::ACC_W;
    localparam int DIFF_W = lrp_pkg::DIFF_W;
    localparam int PRED_W = lrp_pkg::PRED_W;
    localparam int TERM_W = lrp_pkg::TERM_W;
    localparam int RS_W   = ACC_W + 1 - 15;
    localparam int DW_W   = RS_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_POW,
        ST_POWW,
        ST_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic                        open_reg, open_next;
    logic [TAU_W-1:0]            prev_tau_reg, prev_tau_next;
    logic [TEMP_W-1:0]           t1_reg, t1_next;
    logic [TEMP_W-1:0]           t2_reg, t2_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic                        sat_seen_reg, sat_seen_next;
    logic                        last_reg, last_next;
    logic signed [MEAN_W-1:0]    mean_reg, mean_next;
    logic signed [TAU_W:0]       dtau_reg, dtau_next;
    logic signed [TEMP_W:0]      dtemp_reg, dtemp_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [PRED_W-1:0]    value_reg, value_next;
    logic                        sat_res_reg, sat_res_next;
    logic [1:0]                  count_reg, count_next;
    logic                        out_valid_reg, out_valid_next;
    logic [PRED_W-1:0]           out_data_reg, out_data_next;
    logic                        out_sat_reg, out_sat_next;

    logic [lrp_pkg::ORDER_W-1:0] power_order;
    logic [lrp_pkg::ORDER_W-1:0] order_eff;
    lrp_pkg::mul_a_t             mul_a;
    lrp_pkg::mul_b_t             mul_b;
    lrp_pkg::mul_p_t             mul_p;

    logic [TAU_W-1:0]            in_tau;
    logic [TEMP_W-1:0]           in_temp;
    logic [TEMP_W-1:0]           in_surf;
    logic [MEAN_W-1:0]           in_mean;

    logic signed [TERM_W-1:0]    term;
    logic signed [ACC_W:0]       acc_sum;
    logic signed [ACC_W:0]       round_sum;
    logic signed [RS_W-1:0]      rescaled;
    logic signed [DW_W-1:0]      diff_wide;

    lrp_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .power_order (power_order)
    );

    lrp_mult u_mult
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    assign in_tau  = s_tdata[15:0];
    assign in_temp = s_tdata[30:16];
    assign in_surf = s_tdata[45:31];
    assign in_mean = s_tdata[59:46];

    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_a = lrp_pkg::mul_a_t'(dtau_reg);
            mul_b = lrp_pkg::mul_b_t'(dtemp_reg);
        end
        else
        begin
            mul_a = value_reg[lrp_pkg::MUL_A_W-1:0];
            mul_b = lrp_pkg::mul_b_t'(diff_reg);
        end
    end

    always_comb
    begin
        if (power_order < lrp_pkg::ORDER_MIN)
        begin
            order_eff = lrp_pkg::ORDER_MIN;
        end
        else if (power_order > lrp_pkg::ORDER_MAX)
        begin
            order_eff = lrp_pkg::ORDER_MAX;
        end
        else
        begin
            order_eff = power_order;
        end
    end

    assign term      = mul_p[TERM_W-1:0];
    assign acc_sum   = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(term);
    assign round_sum = (ACC_W+1)'(acc_reg) + lrp_pkg::ROUND_HALF;
    assign rescaled  = round_sum[ACC_W:15];
    assign diff_wide = DW_W'(rescaled) - DW_W'(mean_reg);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        prev_tau_next  = prev_tau_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        acc_next       = acc_reg;
        sat_seen_next  = sat_seen_reg;
        last_next      = last_reg;
        mean_next      = mean_reg;
        dtau_next      = dtau_reg;
        dtemp_next     = dtemp_reg;
        diff_next      = diff_reg;
        value_next     = value_reg;
        sat_res_next   = sat_res_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    mean_next = in_mean;
                    if (s_tuser)
                    begin
                        prev_tau_next = in_tau;
                        t1_next       = in_temp;
                        t2_next       = in_surf;
                        acc_next      = '0;
                        sat_seen_next = 1'b0;
                        open_next     = 1'b1;
                        if (s_tlast)
                        begin
                            state_next = ST_RND;
                        end
                    end
                    else if (open_reg)
                    begin
                        dtau_next     = $signed({1'b0, in_tau}) - $signed({1'b0, prev_tau_reg});
                        dtemp_next    = $signed({1'b0, t2_reg}) - $signed({1'b0, in_temp});
                        t2_next       = t1_reg;
                        t1_next       = in_temp;
                        prev_tau_next = in_tau;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                begin
                    acc_next      = acc_sum[ACC_W] ? lrp_pkg::ACC_MIN : lrp_pkg::ACC_MAX;
                    sat_seen_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                state_next = last_reg ? ST_RND : ST_IDLE;
            end
            ST_RND:
            begin
                sat_res_next = sat_seen_reg;
                if (diff_wide > DW_W'(lrp_pkg::DIFF_LIMIT))
                begin
                    diff_next    = lrp_pkg::DIFF_LIMIT;
                    sat_res_next = 1'b1;
                end
                else if (diff_wide < -DW_W'(lrp_pkg::DIFF_LIMIT))
                begin
                    diff_next    = -lrp_pkg::DIFF_LIMIT;
                    sat_res_next = 1'b1;
                end
                else
                begin
                    diff_next = diff_wide[DIFF_W-1:0];
                end
                value_next = PRED_W'(diff_next);
                count_next = 2'(order_eff - 3'd1);
                state_next = (order_eff == lrp_pkg::ORDER_MIN) ? ST_OUT : ST_POW;
            end
            ST_POW:
            begin
                state_next = ST_POWW;
            end
            ST_POWW:
            begin
                value_next = mul_p[PRED_W-1:0];
                count_next = count_reg - 2'd1;
                state_next = (count_reg == 2'd1) ? ST_OUT : ST_POW;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = value_reg;
                    out_sat_next   = sat_res_reg;
                    open_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            prev_tau_reg  <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            acc_reg       <= '0;
            sat_seen_reg  <= 1'b0;
            last_reg      <= 1'b0;
            mean_reg      <= '0;
            dtau_reg      <= '0;
            dtemp_reg     <= '0;
            diff_reg      <= '0;
            value_reg     <= '0;
            sat_res_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            prev_tau_reg  <= prev_tau_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
            acc_reg       <= acc_next;
            sat_seen_reg  <= sat_seen_next;
            last_reg      <= last_next;
            mean_reg      <= mean_next;
            dtau_reg      <= dtau_next;
            dtemp_reg     <= dtemp_next;
            diff_reg      <= diff_next;
            value_reg     <= value_next;
            sat_res_reg   <= sat_res_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(56-PRED_W){1'b0}}, out_data_reg};
    assign m_tuser  = out_sat_reg;

endmodule

// ===== rtl/core/lrp_checker.sv =====
`timescale 1ns / 1ps

module lrp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a new result is loaded only while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a busy sequencer");

    // a first level that does not close the profile leaves the input ready
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !s_tlast |=> s_tready)
        else $error("first level did not return to ready");

    // a single-level profile goes straight to result work
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
        else $error("single-level profile did not start result work");

endmodule

bind lapse_rate_predictor_unit lrp_checker u_lrp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
